// ===== rtl/core/dsa_pkg.sv =====
// Package for the dual sensor step counter: sizes, codes, state and bus types.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package dsa_pkg;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

   localparam int SEC_W      = 6;
   localparam int VAL_W      = 16;
   localparam int ENTRY_W    = SEC_W + VAL_W;
   localparam int SUM_W      = 20;
   localparam int CFG_W      = 18;
   localparam int GAIN_W     = 3;
   localparam int DROP_W     = 6;
   localparam int MIN_W      = 8;
   localparam int DAY_W      = 16;

   localparam logic [SEC_W-1:0]  LAST_SECOND        = 6'd59;
   localparam logic [SEC_W-1:0]  SECONDS_PER_MINUTE = 6'd60;
   localparam logic [DROP_W-1:0] DROP_MAX           = '1;
   localparam logic [MIN_W-1:0]  MIN_MAX            = '1;
   localparam logic [DAY_W-1:0]  DAY_MAX            = '1;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [CFG_W-1:0]  LIMIT_RESET   = -18'sd2000;
   localparam logic signed [CFG_W-1:0]  RELEASE_RESET = 18'sd0;
   localparam logic        [GAIN_W-1:0] GAIN_RESET    = 3'd3;

   typedef enum logic [1:0] {
      REG_LIMIT_LEVEL = 2'd0,
      REG_REARM_LEVEL = 2'd1,
      REG_ARM_GAIN    = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_ALIGN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] limit_level;
      logic signed [CFG_W-1:0] rearm_level;
      logic [GAIN_W-1:0]       arm_gain;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd;
   } fifo_ctl_type;

   typedef struct packed {
      logic equal;
      logic drop_leg;
      logic below_limit;
      logic at_release;
   } pair_result_type;

endpackage

// ===== rtl/core/dsa_csr.sv =====
// APB-style register file: step limit level, re-arm level, arm_gain.
// Depends on dsa_pkg.
`timescale 1ns / 1ps

module dsa_csr
   import dsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_LIMIT_LEVEL: cfg_in.limit_level = signed'(csr_pwdata[CFG_W-1:0]);
            REG_REARM_LEVEL: cfg_in.rearm_level = signed'(csr_pwdata[CFG_W-1:0]);
            REG_ARM_GAIN:    cfg_in.arm_gain    = csr_pwdata[GAIN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_LIMIT_LEVEL: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.limit_level);
         end
         REG_REARM_LEVEL: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.rearm_level);
         end
         REG_ARM_GAIN: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.arm_gain);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_level <= LIMIT_RESET;
         cfg_ff.rearm_level <= RELEASE_RESET;
         cfg_ff.arm_gain    <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/dsa_fifo.sv =====
// Sample FIFO with a registered head read port.
// Depends on dsa_pkg; instantiated once per sensor.
`timescale 1ns / 1ps

module dsa_fifo
   import dsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  fifo_ctl_type       ctl,
   input  logic [ENTRY_W-1:0] wr_data,
   output logic [ENTRY_W-1:0] head_data,
   output logic [FILL_W-1:0]  fill
);

   logic [ENTRY_W-1:0] mem [FIFO_DEPTH];
   logic [ENTRY_W-1:0] head_data_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign head_data = head_data_ff;
   assign fill      = fill_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (ctl.pop) begin
         head_in = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= wr_data;
      end
      if (ctl.rd) begin
         head_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ===== rtl/core/dsa_pair_unit.sv =====
// Shared head compare unit: stamp alignment with minute wrap, weighted sum
// and threshold compares. Depends on dsa_pkg.
`timescale 1ns / 1ps

module dsa_pair_unit
   import dsa_pkg::*;
(
   input  logic [ENTRY_W-1:0] leg_entry,
   input  logic [ENTRY_W-1:0] arm_entry,
   input  cfg_type            cfg,
   output pair_result_type    result
);

   logic [SEC_W-1:0]        leg_sec, arm_sec;
   logic signed [VAL_W-1:0] leg_val, arm_val;
   logic signed [SUM_W-1:0] weighted;
   logic signed [SUM_W-1:0] sum;

   assign leg_sec = leg_entry[ENTRY_W-1:VAL_W];
   assign arm_sec = arm_entry[ENTRY_W-1:VAL_W];
   assign leg_val = signed'(leg_entry[VAL_W-1:0]);
   assign arm_val = signed'(arm_entry[VAL_W-1:0]);

   assign weighted = SUM_W'(signed'({1'b0, cfg.arm_gain})) * SUM_W'(arm_val);
   assign sum      = SUM_W'(leg_val) + weighted;

   always_comb begin
      result.equal       = (leg_sec == arm_sec);
      result.below_limit = (sum < SUM_W'(cfg.limit_level));
      result.at_release  = (sum >= SUM_W'(cfg.rearm_level));
      // 59 is older than anything except 58 (minute wrap)
      priority if (leg_sec == LAST_SECOND && arm_sec != LAST_SECOND - 1'b1) begin
         result.drop_leg = 1'b1;
      end else if (arm_sec == LAST_SECOND && leg_sec != LAST_SECOND - 1'b1) begin
         result.drop_leg = 1'b0;
      end else begin
         result.drop_leg = (leg_sec <= arm_sec);
      end
   end

endmodule

// ===== rtl/core/dual_sensor_align_step_counter.sv =====
// Top level of the dual sensor step counter: sequencer, counters, result register.
// Depends on dsa_pkg, dsa_csr, dsa_fifo and dsa_pair_unit.
//
// Usage:
//   req channel: one transfer per item. req_tuser carries command (tick or
//   sample) and sensor_side; req_tdata carries the seconds stamp and value.
//   rsp channel: exactly one result transfer per item, in order.
//   csr port: APB-style writes of the step limit level (0x0), the re-arm
//   level (0x4) and arm_gain (0x8); write only while the block is idle.
// Sequence:
//   A tick goes from ST_IDLE straight to ST_FINISH. A sample goes through
//   ST_PUSH and then k head compares (drops plus match), k being at most
//   the combined FIFO fill; each compare is one registered head read from
//   both FIFOs followed by one pass through the shared pair unit.
//   req_tready is high only while no item is in work; the next item is taken
//   while the previous result still waits in the output register.
// Reset: synchronous; clears pointers, fills, counters and the step block.
// Stall: a held result keeps its data; a finished item waits for rsp_tready.
`timescale 1ns / 1ps

module dual_sensor_align_step_counter
   import dsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] sample_second, [21:6] sample_value, [23:22] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command, [1] sensor_side
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] pair_matched, [1] step_detected, [7:2] dropped_count,
   // [8] fifo_overflow, [16:9] minute_steps, [24:17] previous_minute_steps,
   // [40:25] daily_steps, [47:41] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type         cfg;
   fifo_ctl_type    leg_ctl, arm_ctl;
   logic [ENTRY_W-1:0] leg_head, arm_head;
   logic [FILL_W-1:0]  leg_fill, arm_fill;
   pair_result_type pair;

   state_type          state_ff, state_in;
   logic               side_ff, side_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               matched_ff, matched_in;
   logic               detected_ff, detected_in;
   logic [DROP_W-1:0]  dropped_ff, dropped_in;
   logic               overflow_ff, overflow_in;
   logic               blocked_ff, blocked_in;
   logic [MIN_W-1:0]   minute_ff, minute_in;
   logic [MIN_W-1:0]   last_minute_ff, last_minute_in;
   logic [DAY_W-1:0]   daily_ff, daily_in;
   logic [SEC_W-1:0]   second_ff, second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               is_step;

   dsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsa_fifo u_leg_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (leg_ctl),
      .wr_data   (entry_ff),
      .head_data (leg_head),
      .fill      (leg_fill)
   );

   dsa_fifo u_arm_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (arm_ctl),
      .wr_data   (entry_ff),
      .head_data (arm_head),
      .fill      (arm_fill)
   );

   dsa_pair_unit u_pair (
      .leg_entry (leg_head),
      .arm_entry (arm_head),
      .cfg       (cfg),
      .result    (pair)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign is_step    = pair.below_limit && !blocked_ff;

   always_comb begin
      state_in       = state_ff;
      side_in        = side_ff;
      entry_in       = entry_ff;
      matched_in     = matched_ff;
      detected_in    = detected_ff;
      dropped_in     = dropped_ff;
      overflow_in    = overflow_ff;
      blocked_in     = blocked_ff;
      minute_in      = minute_ff;
      last_minute_in = last_minute_ff;
      daily_in       = daily_ff;
      second_in      = second_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      leg_ctl        = '0;
      arm_ctl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               side_in     = req_tuser[1];
               entry_in    = {req_tdata[SEC_W-1:0], req_tdata[SEC_W+VAL_W-1:SEC_W]};
               matched_in  = 1'b0;
               detected_in = 1'b0;
               dropped_in  = '0;
               overflow_in = 1'b0;
               if (req_tuser[0]) begin
                  if (second_ff < SECONDS_PER_MINUTE) begin
                     second_in = second_ff + 1'b1;
                  end else begin
                     last_minute_in = minute_ff;
                     minute_in      = '0;
                     second_in      = '0;
                  end
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (side_ff) begin
               if (arm_fill == FILL_W'(FIFO_DEPTH)) begin
                  overflow_in = 1'b1;
               end else begin
                  arm_ctl.push = 1'b1;
               end
            end else begin
               if (leg_fill == FILL_W'(FIFO_DEPTH)) begin
                  overflow_in = 1'b1;
               end else begin
                  leg_ctl.push = 1'b1;
               end
            end
            state_in = ST_READ;
         end
         ST_READ: begin
            if (leg_fill != '0 && arm_fill != '0) begin
               leg_ctl.rd = 1'b1;
               arm_ctl.rd = 1'b1;
               state_in   = ST_ALIGN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ALIGN: begin
            if (pair.equal) begin
               leg_ctl.pop = 1'b1;
               arm_ctl.pop = 1'b1;
               matched_in  = 1'b1;
               if (is_step) begin
                  detected_in = 1'b1;
                  blocked_in  = 1'b1;
                  if (minute_ff != MIN_MAX) begin
                     minute_in = minute_ff + 1'b1;
                  end
                  if (daily_ff != DAY_MAX) begin
                     daily_in = daily_ff + 1'b1;
                  end
               end
               if (pair.at_release) begin
                  blocked_in = 1'b0;
               end
            end else begin
               if (pair.drop_leg) begin
                  leg_ctl.pop = 1'b1;
               end else begin
                  arm_ctl.pop = 1'b1;
               end
               if (dropped_ff != DROP_MAX) begin
                  dropped_in = dropped_ff + 1'b1;
               end
            end
            state_in = ST_READ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, daily_ff, last_minute_ff, minute_ff, overflow_ff,
                               dropped_ff, detected_ff, matched_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         blocked_ff     <= 1'b0;
         minute_ff      <= '0;
         last_minute_ff <= '0;
         daily_ff       <= '0;
         second_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         blocked_ff     <= blocked_in;
         minute_ff      <= minute_in;
         last_minute_ff <= last_minute_in;
         daily_ff       <= daily_in;
         second_ff      <= second_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      entry_ff    <= entry_in;
      matched_ff  <= matched_in;
      detected_ff <= detected_in;
      dropped_ff  <= dropped_in;
      overflow_ff <= overflow_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/dsa_checker.sv =====
// Port-level checks for the dual sensor step counter, bound to the top level.
// Depends on dsa_pkg and dual_sensor_align_step_counter.
`timescale 1ns / 1ps

module dsa_checker
   import dsa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[1] || rsp_tdata[0])
      else $error("step reported without a matched pair");

endmodule

bind dual_sensor_align_step_counter dsa_checker u_dsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for dual_sensor_align_step_counter: stream traffic, APB setup.
// Uses dsa_pkg and the RTL under rtl/core; expected results come from an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;
   import dsa_pkg::*;

   localparam bit CMD_SAMPLE = 1'b0;
   localparam bit CMD_TICK   = 1'b1;
   localparam bit SIDE_LEG   = 1'b0;
   localparam bit SIDE_ARM   = 1'b1;

   localparam int MAX_REPORTED = 10;

   // laid out as rsp_tdata[40:0], lowest field last
   typedef struct packed {
      logic [DAY_W-1:0]  daily_steps;
      logic [MIN_W-1:0]  previous_minute_steps;
      logic [MIN_W-1:0]  minute_steps;
      logic              fifo_overflow;
      logic [DROP_W-1:0] dropped_count;
      logic              step_detected;
      logic              pair_matched;
   } step_report_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dual_sensor_align_step_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // shadow of the block's settings and state
   logic signed [CFG_W-1:0] limit_shadow   = LIMIT_RESET;
   logic signed [CFG_W-1:0] release_shadow = RELEASE_RESET;
   logic [GAIN_W-1:0]       gain_shadow    = GAIN_RESET;

   logic [ENTRY_W-1:0] leg_store [FIFO_DEPTH];
   logic [ENTRY_W-1:0] arm_store [FIFO_DEPTH];
   int leg_rd = 0, leg_wr = 0, leg_count = 0;
   int arm_rd = 0, arm_wr = 0, arm_count = 0;
   bit step_armed_off = 1'b0;
   int minute_total   = 0;
   int last_minute    = 0;
   int day_total      = 0;
   int second_count   = 0;

   step_report_type expected_reports [$];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  ticks_sent    = 0;
   int  reports_seen  = 0;
   int  steps_seen    = 0;
   int  overflow_seen = 0;
   int  max_drop_seen = 0;
   int  csr_writes    = 0;
   bit  req_pace_on   = 1'b1;
   bit  rsp_pace_on   = 1'b1;
   int  long_hold     = 0;
   logic [SEC_W-1:0] sec_now = '0;

   function automatic void record_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTED)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endfunction

   function automatic step_report_type predict_step_report(bit cmd, bit side,
                                                           logic [SEC_W-1:0] sec,
                                                           logic [VAL_W-1:0] val);
      step_report_type r;
      logic [ENTRY_W-1:0] leg_entry, arm_entry;
      logic [SEC_W-1:0] leg_sec, arm_sec;
      bit drop_leg;
      int sum;
      r = '0;
      if (cmd == CMD_TICK) begin
         if (second_count < int'(SECONDS_PER_MINUTE)) begin
            second_count++;
         end else begin
            last_minute  = minute_total;
            minute_total = 0;
            second_count = 0;
         end
      end else begin
         if (side == SIDE_ARM) begin
            if (arm_count >= FIFO_DEPTH) begin
               r.fifo_overflow = 1'b1;
            end else begin
               arm_store[arm_wr] = {sec, val};
               arm_wr = (arm_wr + 1) % FIFO_DEPTH;
               arm_count++;
            end
         end else begin
            if (leg_count >= FIFO_DEPTH) begin
               r.fifo_overflow = 1'b1;
            end else begin
               leg_store[leg_wr] = {sec, val};
               leg_wr = (leg_wr + 1) % FIFO_DEPTH;
               leg_count++;
            end
         end
         while (leg_count != 0 && arm_count != 0) begin
            leg_entry = leg_store[leg_rd];
            arm_entry = arm_store[arm_rd];
            leg_sec   = leg_entry[ENTRY_W-1:VAL_W];
            arm_sec   = arm_entry[ENTRY_W-1:VAL_W];
            if (leg_sec != arm_sec) begin
               // a head stamped 59 counts as older unless the other one is 58
               if (leg_sec == LAST_SECOND && arm_sec != LAST_SECOND - 1)
                  drop_leg = 1'b1;
               else if (arm_sec == LAST_SECOND && leg_sec != LAST_SECOND - 1)
                  drop_leg = 1'b0;
               else
                  drop_leg = (leg_sec <= arm_sec);
               if (drop_leg) begin
                  leg_rd = (leg_rd + 1) % FIFO_DEPTH;
                  leg_count--;
               end else begin
                  arm_rd = (arm_rd + 1) % FIFO_DEPTH;
                  arm_count--;
               end
               if (r.dropped_count != DROP_MAX)
                  r.dropped_count++;
            end else begin
               sum = int'($signed(leg_entry[VAL_W-1:0]))
                   + int'(gain_shadow) * int'($signed(arm_entry[VAL_W-1:0]));
               leg_rd = (leg_rd + 1) % FIFO_DEPTH;
               leg_count--;
               arm_rd = (arm_rd + 1) % FIFO_DEPTH;
               arm_count--;
               r.pair_matched = 1'b1;
               if (sum < int'(limit_shadow) && !step_armed_off) begin
                  r.step_detected = 1'b1;
                  step_armed_off  = 1'b1;
                  if (minute_total < int'(MIN_MAX))
                     minute_total++;
                  if (day_total < int'(DAY_MAX))
                     day_total++;
               end
               if (sum >= int'(release_shadow))
                  step_armed_off = 1'b0;
            end
         end
      end
      r.minute_steps          = MIN_W'(minute_total);
      r.previous_minute_steps = MIN_W'(last_minute);
      r.daily_steps           = DAY_W'(day_total);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!req_pace_on)
         return 0;
      r = $urandom_range(99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   function automatic void advance_second();
      if ($urandom_range(19) == 0)
         sec_now = SEC_W'($urandom_range(59));
      else
         sec_now = (sec_now == LAST_SECOND) ? '0 : sec_now + 1'b1;
   endfunction

   // entered and left at a rising edge; valid stays up when no gap follows
   task automatic send_item(bit cmd, bit side, logic [SEC_W-1:0] sec, logic [VAL_W-1:0] val);
      int gap;
      req_tuser  <= {side, cmd};
      req_tdata  <= {2'b00, val, sec};
      req_tvalid <= 1'b1;
      forever begin
         @(posedge clock);
         if (req_tready === 1'b1)
            break;
      end
      expected_reports.push_back(predict_step_report(cmd, side, sec, val));
      items_sent++;
      if (cmd == CMD_TICK)
         ticks_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_writes++;
      case (idx)
         REG_LIMIT_LEVEL: begin
            limit_shadow = data[CFG_W-1:0];
            mask = (1 << CFG_W) - 1;
         end
         REG_REARM_LEVEL: begin
            release_shadow = data[CFG_W-1:0];
            mask = (1 << CFG_W) - 1;
         end
         default: begin
            gain_shadow = data[GAIN_W-1:0];
            mask = (1 << GAIN_W) - 1;
         end
      endcase
      if ((readback & mask) !== (data & mask))
         record_error($sformatf("register %s readback expected 0x%0h got 0x%0h",
                                idx.name(), data & mask, readback & mask));
   endtask

   task automatic configure(int limit, int rel, int gain);
      write_csr(REG_LIMIT_LEVEL, CSR_DATA_W'(limit));
      write_csr(REG_REARM_LEVEL, CSR_DATA_W'(rel));
      write_csr(REG_ARM_GAIN, CSR_DATA_W'(gain));
   endtask

   // mostly aligned leg/arm pairs, with ticks, lone samples and noise bursts
   task automatic run_random_items(int count, int tick_pct);
      int sent, r, burst;
      bit side;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         if (r < tick_pct) begin
            send_item(CMD_TICK, 1'($urandom_range(1)), SEC_W'($urandom_range(63)),
                      pick_value());
            sent++;
         end else if (r < tick_pct + (100 - tick_pct) * 7 / 10) begin
            side = 1'($urandom_range(1));
            send_item(CMD_SAMPLE, side, sec_now, pick_value());
            send_item(CMD_SAMPLE, !side, sec_now, pick_value());
            sent += 2;
            advance_second();
         end else if (r < 94) begin
            send_item(CMD_SAMPLE, 1'($urandom_range(1)), sec_now, pick_value());
            sent++;
            advance_second();
         end else begin
            burst = ($urandom_range(3) == 0) ? $urandom_range(20, 14) : 1;
            side  = 1'($urandom_range(1));
            repeat (burst) begin
               send_item(CMD_SAMPLE, side, SEC_W'($urandom_range(63)), pick_value());
               sent++;
            end
         end
      end
   endtask

   task automatic test_corner_items();
      send_item(CMD_TICK, SIDE_ARM, 6'd63, 16'hFFFF);
      send_item(CMD_TICK, SIDE_LEG, 6'd0, 16'h0000);
      // most negative pair: step, block stays set
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd0, 16'h8000);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd0, 16'h8000);
      // zero sum re-arms
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd1, 16'h0000);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd1, 16'h0000);
      // leg at 59 against arm at 0: minute wrap drops the leg
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd59, 16'h7FFF);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd0, 16'h0001);
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd0, 16'hFFFF);
      // arm at 58 against leg at 59: the arm is older
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd58, 16'h1234);
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd59, 16'h8000);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd59, 16'h8000);
      // stamps past 59 compare as plain numbers
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd63, 16'h5555);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd62, 16'hAAAA);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd60, 16'h2AAA);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd63, 16'h7FFF);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd61, 16'hB1E0);
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd61, 16'hB1E0);
      drain_results();
   endtask

   task automatic test_fifo_overflow();
      for (int k = 0; k <= FIFO_DEPTH; k++)
         send_item(CMD_SAMPLE, SIDE_ARM, SEC_W'(10 + k), pick_value());
      // newer leg stamp flushes every arm head
      send_item(CMD_SAMPLE, SIDE_LEG, 6'd40, 16'hC000);
      send_item(CMD_SAMPLE, SIDE_ARM, 6'd40, 16'hC000);
      drain_results();
   endtask

   task automatic test_random_default();
      run_random_items(300, 25);
      drain_results();
   endtask

   task automatic test_no_steps_unpaced();
      configure(-131072, 131071, 0);
      req_pace_on = 1'b0;
      rsp_pace_on = 1'b0;
      run_random_items(150, 25);
      drain_results();
      req_pace_on = 1'b1;
      rsp_pace_on = 1'b1;
   endtask

   task automatic test_minute_saturation();
      configure(131071, -131072, 7);
      run_random_items(540, 2);
      drain_results();
   endtask

   task automatic test_backpressure();
      configure($urandom_range(131071) - 65536, $urandom_range(131071) - 65536,
                $urandom_range(7));
      req_pace_on = 1'b0;
      long_hold   = 300;
      run_random_items(40, 10);
      drain_results();
      req_pace_on = 1'b1;
   endtask

   task automatic test_random_mixed();
      run_random_items(200, 30);
      drain_results();
   endtask

   // result side pacing; a long hold is counted here cycle by cycle
   initial begin : rsp_pacer
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (rsp_pace_on && $urandom_range(99) < 25) begin
            stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_checker
      step_report_type got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = rsp_tdata[$bits(step_report_type)-1:0];
         reports_seen++;
         if (got.step_detected === 1'b1)
            steps_seen++;
         if (got.fifo_overflow === 1'b1)
            overflow_seen++;
         if (int'(got.dropped_count) > max_drop_seen)
            max_drop_seen = int'(got.dropped_count);
         if (expected_reports.size() == 0) begin
            record_error($sformatf("result transfer %0d with nothing expected: 0x%0h",
                                   reports_seen, rsp_tdata));
         end else begin
            want = expected_reports.pop_front();
            if (got.pair_matched !== want.pair_matched)
               record_error($sformatf("result %0d pair_matched expected %0d got %0d",
                                      reports_seen, want.pair_matched, got.pair_matched));
            if (got.step_detected !== want.step_detected)
               record_error($sformatf("result %0d step_detected expected %0d got %0d",
                                      reports_seen, want.step_detected, got.step_detected));
            if (got.dropped_count !== want.dropped_count)
               record_error($sformatf("result %0d dropped_count expected %0d got %0d",
                                      reports_seen, want.dropped_count, got.dropped_count));
            if (got.fifo_overflow !== want.fifo_overflow)
               record_error($sformatf("result %0d fifo_overflow expected %0d got %0d",
                                      reports_seen, want.fifo_overflow, got.fifo_overflow));
            if (got.minute_steps !== want.minute_steps)
               record_error($sformatf("result %0d minute_steps expected %0d got %0d",
                                      reports_seen, want.minute_steps, got.minute_steps));
            if (got.previous_minute_steps !== want.previous_minute_steps)
               record_error($sformatf("result %0d previous_minute_steps expected %0d got %0d",
                                      reports_seen, want.previous_minute_steps,
                                      got.previous_minute_steps));
            if (got.daily_steps !== want.daily_steps)
               record_error($sformatf("result %0d daily_steps expected %0d got %0d",
                                      reports_seen, want.daily_steps, got.daily_steps));
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d results outstanding", expected_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : test_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_items();
      test_fifo_overflow();
      test_random_default();
      test_no_steps_unpaced();
      test_minute_saturation();
      test_backpressure();
      test_random_mixed();
      drain_results();
      repeat (100) @(posedge clock);
      if (expected_reports.size() != 0)
         record_error($sformatf("%0d expected results never arrived",
                                expected_reports.size()));
      $display("Sent %0d items (%0d ticks), checked %0d results over %0d register writes.",
               items_sent, ticks_sent, reports_seen, csr_writes);
      $display("Steps seen %0d, overflows %0d, longest drop run %0d, mismatches %0d.",
               steps_seen, overflow_seen, max_drop_seen, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== dual_sensor_align_step_counter.f =====
rtl/core/dsa_pkg.sv
rtl/core/dsa_csr.sv
rtl/core/dsa_fifo.sv
rtl/core/dsa_pair_unit.sv
rtl/core/dual_sensor_align_step_counter.sv
rtl/core/dsa_checker.sv
dv/tb_top.sv
